@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the slot policy block
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pwlru_pkg.sv @@
// types and constants for the protected-window lru slot policy
// no dependencies; used by protected_window_lru_slot_policy
`timescale 1ns / 1ps

package pwlru_pkg;

    localparam int SLOTS     = 12;
    localparam int SLOT_W    = 4;
    localparam int TAG_W     = 8;
    localparam int AGE_W     = 32;
    localparam int COUNT_W   = 9;
    localparam int WINDOW_W  = 8;
    localparam int KIND_W    = 3;
    localparam int MAX_ITEMS = 256;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOUCH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic CFG_ITEM_COUNT     = 1'b0;
    localparam logic CFG_PROTECT_WINDOW = 1'b1;

    localparam logic [WINDOW_W-1:0] PROTECT_WINDOW_RESET = 8'd4;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

@@ rtl/protected_window_lru_slot_policy.sv @@
// protected-window lru slot policy: slot table, scan sequencer and result register
// depends on pwlru_pkg and assert_macros.svh
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready) carries one request: kind, item,
// current_position, commit_slot. Output channel (out_valid/out_ready)
// returns exactly one transaction per request: hit and slot.
// Find, touch and allocate scan the twelve slots one per cycle through a
// single tag compare / distance / age compare unit, then reach a final
// finish step, where touch and allocate update the table. Commit, clear and
// unknown kinds skip the scan and go straight to that finish step.
// The result sits in an output register; while it waits for out_ready the
// block goes back to idle and takes the next request, and only stalls that
// next request at its final step if the earlier result is still unclaimed.
// Configuration (cfg_write, cfg_index, cfg_data) must be written while idle;
// the block itself does not enforce this. Index 0 is item_count, index 1 protect_window.
// Reset empties the table, zeroes ages and the use counter, sets
// item_count to 0 and protect_window to 4, and leaves no result pending.

`include "assert_macros.svh"

module protected_window_lru_slot_policy (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [pwlru_pkg::COUNT_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pwlru_pkg::KIND_W-1:0]        kind,
    input  logic [pwlru_pkg::TAG_W-1:0]         item,
    input  logic [pwlru_pkg::TAG_W-1:0]         current_position,
    input  logic [pwlru_pkg::SLOT_W-1:0]        commit_slot,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [pwlru_pkg::SLOT_W-1:0]        slot
);

    localparam int SW = pwlru_pkg::SLOT_W;
    localparam int TW = pwlru_pkg::TAG_W;
    localparam int AW = pwlru_pkg::AGE_W;
    localparam int CW = pwlru_pkg::COUNT_W;
    localparam int DW = CW + 2;

    localparam logic [SW-1:0] LAST_SLOT = SW'(pwlru_pkg::SLOTS - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(pwlru_pkg::MAX_ITEMS);

    pwlru_pkg::state_t state_reg;

    // configuration
    logic [CW-1:0]                    item_count_reg;
    logic [pwlru_pkg::WINDOW_W-1:0]   protect_window_reg;

    // slot table
    logic [pwlru_pkg::SLOTS-1:0]      ready_reg;
    logic [TW-1:0]                    tag_reg [pwlru_pkg::SLOTS];
    logic [AW-1:0]                    age_reg [pwlru_pkg::SLOTS];
    logic [AW-1:0]                    use_counter_reg;
    logic [AW-1:0]                    use_counter_next;

    // captured request
    logic [pwlru_pkg::KIND_W-1:0]     kind_reg;
    logic [TW-1:0]                    item_reg;
    logic [TW-1:0]                    cur_reg;
    logic [SW-1:0]                    cslot_reg;

    // scan state
    logic [SW-1:0]                    scan_idx_reg;
    logic                             hit_found_reg;
    logic [SW-1:0]                    hit_idx_reg;
    logic                             free_found_reg;
    logic [SW-1:0]                    free_idx_reg;
    logic                             unprot_found_reg;
    logic [AW-1:0]                    oldest_reg;
    logic [SW-1:0]                    pick_idx_reg;

    // result
    logic                             res_hit_reg;
    logic [SW-1:0]                    res_slot_reg;
    logic                             out_valid_reg;
    logic                             out_hit_reg;
    logic [SW-1:0]                    out_slot_reg;

    // shared per-slot unit
    logic                             cur_ready;
    logic [TW-1:0]                    cur_tag;
    logic [AW-1:0]                    cur_age;
    logic                             cur_match;
    logic [CW-1:0]                    n_eff;
    logic signed [DW-1:0]             n_s;
    logic signed [DW-1:0]             dist_raw;
    logic signed [DW-1:0]             dist_adj;
    logic                             cur_prot;
    logic                             age_older;

    logic                             in_fire;
    logic                             needs_scan;
    logic                             cslot_valid;
    logic [SW-1:0]                    victim_idx;
    logic                             out_free;

    assign in_ready  = (state_reg == pwlru_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign slot      = out_slot_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign needs_scan = (kind == pwlru_pkg::KIND_FIND) || (kind == pwlru_pkg::KIND_TOUCH)
                     || (kind == pwlru_pkg::KIND_ALLOC);

    assign use_counter_next = use_counter_reg + AW'(1);
    assign cslot_valid      = (cslot_reg <= LAST_SLOT);
    assign victim_idx       = free_found_reg ? free_idx_reg : pick_idx_reg;

    // slot under the scan pointer
    assign cur_ready = ready_reg[scan_idx_reg];
    assign cur_tag   = tag_reg[scan_idx_reg];
    assign cur_age   = age_reg[scan_idx_reg];
    assign cur_match = cur_ready && (cur_tag == item_reg);

    // forward distance from the current position, one conditional wrap
    assign n_eff    = (item_count_reg > MAX_COUNT) ? MAX_COUNT : item_count_reg;
    assign n_s      = $signed({2'b00, n_eff});
    assign dist_raw = $signed({3'b000, cur_tag}) + n_s - $signed({3'b000, cur_reg});
    assign dist_adj = (dist_raw >= n_s) ? (dist_raw - n_s) : dist_raw;
    assign cur_prot = (n_eff != '0) && (dist_adj >= 0) && (dist_adj < n_s)
                   && (dist_adj <= $signed({3'b000, protect_window_reg}));
    assign age_older = (cur_age < oldest_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg     <= '0;
            protect_window_reg <= pwlru_pkg::PROTECT_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pwlru_pkg::CFG_ITEM_COUNT:     item_count_reg     <= cfg_data;
                pwlru_pkg::CFG_PROTECT_WINDOW: protect_window_reg <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // sequencer, scan bookkeeping and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pwlru_pkg::ST_IDLE;
            scan_idx_reg     <= '0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            unprot_found_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if ((state_reg == pwlru_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                pwlru_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        scan_idx_reg     <= '0;
                        hit_found_reg    <= 1'b0;
                        free_found_reg   <= 1'b0;
                        unprot_found_reg <= 1'b0;
                        state_reg <= needs_scan ? pwlru_pkg::ST_SCAN : pwlru_pkg::ST_FINISH;
                    end
                end
                pwlru_pkg::ST_SCAN:
                begin
                    if (cur_match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    if (!cur_ready && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (cur_ready && !cur_prot)
                    begin
                        unprot_found_reg <= 1'b1;
                    end
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_reg <= pwlru_pkg::ST_FINISH;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + SW'(1);
                    end
                end
                pwlru_pkg::ST_FINISH:
                begin
                    state_reg <= pwlru_pkg::ST_DONE;
                end
                pwlru_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= pwlru_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= pwlru_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload: captured request, scan picks, result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg     <= kind;
            item_reg     <= item;
            cur_reg      <= current_position;
            cslot_reg    <= commit_slot;
            oldest_reg   <= '1;
            pick_idx_reg <= '0;
        end

        if (state_reg == pwlru_pkg::ST_SCAN)
        begin
            if (cur_match && !hit_found_reg)
            begin
                hit_idx_reg <= scan_idx_reg;
            end
            if (!cur_ready && !free_found_reg)
            begin
                free_idx_reg <= scan_idx_reg;
            end
            // first unprotected wins, later ones if older; else oldest protected slot
            if (cur_ready)
            begin
                if (!cur_prot && (!unprot_found_reg || age_older))
                begin
                    oldest_reg   <= cur_age;
                    pick_idx_reg <= scan_idx_reg;
                end
                else if (!unprot_found_reg && age_older)
                begin
                    oldest_reg   <= cur_age;
                    pick_idx_reg <= scan_idx_reg;
                end
            end
        end

        if (state_reg == pwlru_pkg::ST_FINISH)
        begin
            unique case (kind_reg) inside
                pwlru_pkg::KIND_FIND, pwlru_pkg::KIND_TOUCH:
                begin
                    res_hit_reg  <= hit_found_reg;
                    res_slot_reg <= hit_found_reg ? hit_idx_reg : '0;
                end
                pwlru_pkg::KIND_ALLOC:
                begin
                    res_hit_reg  <= hit_found_reg;
                    res_slot_reg <= hit_found_reg ? hit_idx_reg : victim_idx;
                end
                pwlru_pkg::KIND_COMMIT:
                begin
                    res_hit_reg  <= 1'b0;
                    res_slot_reg <= cslot_valid ? cslot_reg : '0;
                end
                default:
                begin
                    res_hit_reg  <= 1'b0;
                    res_slot_reg <= '0;
                end
            endcase
        end

        if ((state_reg == pwlru_pkg::ST_DONE) && out_free)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= res_slot_reg;
        end
    end

    // tags need no reset: only ready slots are ever compared
    always_ff @(posedge clk)
    begin
        if (state_reg == pwlru_pkg::ST_FINISH)
        begin
            if ((kind_reg == pwlru_pkg::KIND_ALLOC) && !hit_found_reg)
            begin
                tag_reg[victim_idx] <= item_reg;
            end
            else if ((kind_reg == pwlru_pkg::KIND_COMMIT) && cslot_valid)
            begin
                tag_reg[cslot_reg] <= item_reg;
            end
        end
    end

    // ready flags, ages and use counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg       <= '0;
            use_counter_reg <= '0;
            for (int i = 0; i < pwlru_pkg::SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (state_reg == pwlru_pkg::ST_FINISH)
        begin
            unique case (kind_reg)
                pwlru_pkg::KIND_TOUCH:
                begin
                    if (hit_found_reg)
                    begin
                        use_counter_reg      <= use_counter_next;
                        age_reg[hit_idx_reg] <= use_counter_next;
                    end
                end
                pwlru_pkg::KIND_ALLOC:
                begin
                    if (!hit_found_reg)
                    begin
                        ready_reg[victim_idx] <= 1'b0;
                    end
                end
                pwlru_pkg::KIND_COMMIT:
                begin
                    if (cslot_valid)
                    begin
                        ready_reg[cslot_reg] <= 1'b1;
                        use_counter_reg      <= use_counter_next;
                        age_reg[cslot_reg]   <= use_counter_next;
                    end
                end
                pwlru_pkg::KIND_CLEAR:
                begin
                    ready_reg       <= '0;
                    use_counter_reg <= '0;
                    for (int i = 0; i < pwlru_pkg::SLOTS; i++)
                    begin
                        age_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_scan_in_range, (state_reg == pwlru_pkg::ST_SCAN) |-> (scan_idx_reg <= LAST_SLOT), "scan pointer past last slot")
    `ASSERT_ALWAYS(a_result_slot_in_range, out_valid_reg |-> (out_slot_reg <= LAST_SLOT), "result slot out of range")
    `ASSERT_NEXT(a_counter_only_at_finish, state_reg != pwlru_pkg::ST_FINISH, $stable(use_counter_reg), "use counter moved outside the update step")
    `ASSERT_NEXT(a_result_loaded_when_free, (state_reg == pwlru_pkg::ST_DONE) && out_free, out_valid_reg && (state_reg == pwlru_pkg::ST_IDLE), "result not loaded on release")

endmodule
